[hw/rtl/locality_aware_task_dispatch_top_defines.svh]
// Assertion macros shared by the checker of the dispatch table.
// Relies on i_clk and i_rst_n being visible where a macro is used.
`ifndef LOCALITY_AWARE_TASK_DISPATCH_TOP_DEFINES_SVH
`define LOCALITY_AWARE_TASK_DISPATCH_TOP_DEFINES_SVH

// Same-cycle implication, switched off while reset is held
`define LATD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, switched off while reset is held
`define LATD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is also checked across reset
`define LATD_ASSERT_NEXT_RST(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/latd_pkg.sv]
// Shared types, widths and codes of the locality-aware task dispatch table.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package latd_pkg;

    // table geometry
    localparam int TASK_DEPTH = 64;
    localparam int CNT_W      = $clog2(TASK_DEPTH + 1);
    localparam int CHUNK_W    = 16;
    localparam int NODE_W     = 8;

    // input word kinds (s_axis_tuser)
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_REQ  = 1'b1;

    // result status codes (m_axis_tuser)
    localparam logic [1:0] ST_LOCAL  = 2'd0;
    localparam logic [1:0] ST_REMOTE = 2'd1;
    localparam logic [1:0] ST_NONE   = 2'd2;
    localparam logic [1:0] ST_REJECT = 2'd3;

    // per-cycle commands broadcast to every cell
    typedef struct packed {
        logic load;   // write the incoming task into the tail cell
        logic cmp;    // latch the node compare against the requester
        logic shift;  // close the gap: cells at/after the pick take their neighbour
    } t_cell_ctl;

endpackage

[hw/rtl/latd_cell.sv]
// One slot of the task chain: holds a chunk id, a preferred node and a match flag.
// Depends on latd_pkg.
`timescale 1ns / 1ps

module latd_cell
    import latd_pkg::*;
(
    input  logic               i_clk,
    input  t_cell_ctl          i_ctl,
    input  logic               i_tail,      // this cell is the first free slot
    input  logic               i_occ,       // this cell holds a live task
    input  logic               i_take,      // at or after the picked slot
    input  logic [CHUNK_W-1:0] i_in_chunk,
    input  logic [NODE_W-1:0]  i_in_node,
    input  logic [NODE_W-1:0]  i_req,
    input  logic [CHUNK_W-1:0] i_nxt_chunk, // neighbour towards the tail
    input  logic [NODE_W-1:0]  i_nxt_node,
    output logic [CHUNK_W-1:0] o_chunk,
    output logic [NODE_W-1:0]  o_node,
    output logic               o_match
);

    logic [CHUNK_W-1:0] r_chunk;
    logic [NODE_W-1:0]  r_node;
    logic               r_match;

    // payload: append at the tail, or shift down one place on removal
    always_ff @(posedge i_clk) begin
        if (i_ctl.load && i_tail) begin
            r_chunk <= i_in_chunk;
            r_node  <= i_in_node;
        end else if (i_ctl.shift && i_take) begin
            r_chunk <= i_nxt_chunk;
            r_node  <= i_nxt_node;
        end
    end

    // local compare, registered for the pick stage
    always_ff @(posedge i_clk) begin
        if (i_ctl.cmp) begin
            r_match <= i_occ && (r_node == i_req);
        end
    end

    assign o_chunk = r_chunk;
    assign o_node  = r_node;
    assign o_match = r_match;

endmodule

[hw/rtl/latd_sel.sv]
// Pick unit: finds the oldest matching cell (or the head) and muxes its task out.
// Depends on latd_pkg.
`timescale 1ns / 1ps

module latd_sel
    import latd_pkg::*;
(
    input  logic [TASK_DEPTH-1:0]              i_match,
    input  logic [TASK_DEPTH-1:0][CHUNK_W-1:0] i_chunks,
    input  logic [TASK_DEPTH-1:0][NODE_W-1:0]  i_nodes,
    output logic                               o_found,
    output logic [TASK_DEPTH-1:0]              o_take,
    output logic [CHUNK_W-1:0]                 o_chunk,
    output logic [NODE_W-1:0]                  o_node
);

    localparam logic [TASK_DEPTH-1:0] ONE = {{(TASK_DEPTH-1){1'b0}}, 1'b1};

    logic [TASK_DEPTH-1:0] eff;
    logic [TASK_DEPTH-1:0] onehot;

    // lowest set bit; the head when nothing matched
    assign o_found = |i_match;
    assign eff     = o_found ? i_match : ONE;
    assign onehot  = eff & (~eff + ONE);
    // picked cell and everything behind it shift down
    assign o_take  = ~(onehot - ONE);

    // one-hot mux of the picked task
    always_comb begin
        o_chunk = '0;
        o_node  = '0;
        for (int i = 0; i < TASK_DEPTH; i++) begin
            if (onehot[i]) begin
                o_chunk = o_chunk | i_chunks[i];
                o_node  = o_node | i_nodes[i];
            end
        end
    end

endmodule

[hw/rtl/locality_aware_task_dispatch_top.sv]
// Top level of the locality-aware task dispatch table: chain of cells, pick unit,
// sequencer and output register. Depends on latd_pkg, latd_cell and latd_sel.
//
// Usage:
// s_axis carries one word per item. tuser is the kind: 0 loads a task
// (chunk id, preferred node) at the tail, 1 requests a task for a worker.
// m_axis carries results: tuser is the status (0 local, 1 non-local,
// 2 none left, 3 load rejected), tdata the chunk id and node handed out,
// zero for status 2 and 3. A load into a free slot gives no result.
// A load that fits is taken without leaving the idle state, so the next word can follow at once.
// A request on a non-empty table first latches every cell's node compare, then picks
// the oldest match (or the head if none matched) and shifts the cells behind it down
// one place; a rejected load or a request on an empty table goes straight to the emit
// step. The result is registered and shows on m_axis the cycle after.
// Reset (i_rst_n low, synchronous) empties the table and drops any result.
// If the receiver stalls, one result waits in the output register and the
// block still takes new words; it holds in the pick or emit step only when
// a second result would need the occupied output register.
`timescale 1ns / 1ps

module locality_aware_task_dispatch_top
    import latd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // chunk_id[15:0], pref_node[23:16], requester[31:24]
    input  logic        s_axis_tuser,  // kind[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,  // out_chunk[15:0], out_node[23:16]
    output logic [1:0]  m_axis_tuser   // status[1:0]
);

    // sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SEL  = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [1:0]       r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [1:0]       r_pend,  n_pend;

    logic               r_out_valid;
    logic [1:0]         r_out_st;
    logic [CHUNK_W-1:0] r_out_chunk;
    logic [NODE_W-1:0]  r_out_node;

    logic               out_wr;
    logic [1:0]         out_st;
    logic [CHUNK_W-1:0] out_chunk;
    logic [NODE_W-1:0]  out_node;

    t_cell_ctl ctl;
    logic      accept;
    logic      slot_free;
    logic      full;

    logic [CHUNK_W-1:0] in_chunk;
    logic [NODE_W-1:0]  in_node;
    logic [NODE_W-1:0]  in_req;

    logic [TASK_DEPTH-1:0]              tail;
    logic [TASK_DEPTH-1:0]              occ;
    logic [TASK_DEPTH-1:0]              match;
    logic [TASK_DEPTH-1:0]              take;
    logic [TASK_DEPTH-1:0][CHUNK_W-1:0] chunks;
    logic [TASK_DEPTH-1:0][NODE_W-1:0]  nodes;

    logic               sel_found;
    logic [CHUNK_W-1:0] sel_chunk;
    logic [NODE_W-1:0]  sel_node;

    // input word unpacking
    assign in_chunk = s_axis_tdata[15:0];
    assign in_node  = s_axis_tdata[23:16];
    assign in_req   = s_axis_tdata[31:24];

    assign s_axis_tready = (r_state == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign slot_free     = !r_out_valid || m_axis_tready;
    assign full          = (r_count == CNT_W'(TASK_DEPTH));

    // cell chain
    for (genvar g = 0; g < TASK_DEPTH; g++) begin : g_cell
        logic [CHUNK_W-1:0] nxt_chunk;
        logic [NODE_W-1:0]  nxt_node;

        assign tail[g] = (r_count == CNT_W'(g));
        assign occ[g]  = (CNT_W'(g) < r_count);

        if (g == TASK_DEPTH - 1) begin : g_end
            assign nxt_chunk = '0;
            assign nxt_node  = '0;
        end else begin : g_mid
            assign nxt_chunk = chunks[g+1];
            assign nxt_node  = nodes[g+1];
        end

        latd_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (ctl),
            .i_tail      (tail[g]),
            .i_occ       (occ[g]),
            .i_take      (take[g]),
            .i_in_chunk  (in_chunk),
            .i_in_node   (in_node),
            .i_req       (in_req),
            .i_nxt_chunk (nxt_chunk),
            .i_nxt_node  (nxt_node),
            .o_chunk     (chunks[g]),
            .o_node      (nodes[g]),
            .o_match     (match[g])
        );
    end

    // oldest-match pick
    latd_sel u_sel (
        .i_match  (match),
        .i_chunks (chunks),
        .i_nodes  (nodes),
        .o_found  (sel_found),
        .o_take   (take),
        .o_chunk  (sel_chunk),
        .o_node   (sel_node)
    );

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_pend    = r_pend;
        ctl       = '0;
        out_wr    = 1'b0;
        out_st    = r_pend;
        out_chunk = '0;
        out_node  = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (s_axis_tuser == KIND_LOAD) begin
                        if (full) begin
                            n_pend  = ST_REJECT;
                            n_state = S_EMIT;
                        end else begin
                            ctl.load = 1'b1;
                            n_count  = r_count + CNT_W'(1);
                        end
                    end else if (r_count == '0) begin
                        n_pend  = ST_NONE;
                        n_state = S_EMIT;
                    end else begin
                        ctl.cmp = 1'b1;
                        n_state = S_SEL;
                    end
                end
            end
            S_SEL: begin
                if (slot_free) begin
                    out_wr    = 1'b1;
                    out_st    = sel_found ? ST_LOCAL : ST_REMOTE;
                    out_chunk = sel_chunk;
                    out_node  = sel_node;
                    ctl.shift = 1'b1;
                    n_count   = r_count - CNT_W'(1);
                    n_state   = S_IDLE;
                end
            end
            S_EMIT: begin
                if (slot_free) begin
                    out_wr  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend <= n_pend;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_wr) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_wr) begin
            r_out_st    <= out_st;
            r_out_chunk <= out_chunk;
            r_out_node  <= out_node;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_st;
    assign m_axis_tdata  = {r_out_node, r_out_chunk};

endmodule

[hw/rtl/latd_chk.sv]
// Port-level checker for the dispatch table, bound to the top level.
// Depends on latd_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "locality_aware_task_dispatch_top_defines.svh"

module latd_chk
    import latd_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [31:0] s_axis_tdata,
    input logic        s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    // reset drops any pending result
    `LATD_ASSERT_NEXT_RST(a_rst_clear, !i_rst_n, !m_axis_tvalid, "result valid after reset")

    // a stalled result word is held
    `LATD_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

    // no task handed out on a reject or an empty table
    `LATD_ASSERT_SAME(a_zero_data, m_axis_tvalid && (m_axis_tuser == ST_NONE || m_axis_tuser == ST_REJECT), m_axis_tdata == '0, "non-zero data without a task")

    // a request occupies the pick or emit step, so no word is taken right after it
    `LATD_ASSERT_NEXT(a_req_busy, s_axis_tvalid && s_axis_tready && (s_axis_tuser == KIND_REQ), !s_axis_tready, "word taken during request pick")

endmodule

bind locality_aware_task_dispatch_top latd_chk u_latd_chk (.*);
